@@ design/kvbd_pkg.sv @@
// ----------------------------------------------------------------------------
// kvbd_pkg
// Types and codes shared by the key/value box deframer and its testbench.
// ----------------------------------------------------------------------------
package kvbd_pkg;

    // Parser phase within a pair
    typedef enum logic [1:0] {
        PH_KEY_LEN  = 2'd0,
        PH_KEY_DATA = 2'd1,
        PH_VAL_LEN  = 2'd2,
        PH_VAL_DATA = 2'd3
    } t_phase;

    // Byte classification
    typedef enum logic [2:0] {
        KIND_KLEN_HI = 3'd0,
        KIND_KLEN_LO = 3'd1,
        KIND_KEY     = 3'd2,
        KIND_VLEN_HI = 3'd3,
        KIND_VLEN_LO = 3'd4,
        KIND_VALUE   = 3'd5,
        KIND_BOX_END = 3'd6,
        KIND_NONE    = 3'd7
    } t_kind;

    // Result status
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_KEY_LEN = 2'd1,
        ST_EMPTY_BOX   = 2'd2,
        ST_REFUSED     = 2'd3
    } t_status;

    // Sticky error held by the parser
    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_BAD_KEY_LEN = 2'd1,
        ERR_EMPTY_BOX   = 2'd2
    } t_error;

    // Request commands
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

endpackage : kvbd_pkg

@@ design/kvbd_in_if.sv @@
// ----------------------------------------------------------------------------
// kvbd_in_if
// Request channel of the deframer: one command and one received byte.
// ----------------------------------------------------------------------------
interface kvbd_in_if;

    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);

endinterface : kvbd_in_if

@@ design/kvbd_out_if.sv @@
// ----------------------------------------------------------------------------
// kvbd_out_if
// Result channel of the deframer: one classified byte per request.
// ----------------------------------------------------------------------------
interface kvbd_out_if;

    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  kind;
    logic [15:0] offset;
    logic        field_last;
    logic        box_end;
    logic [1:0]  status;

    modport source (
        output valid, output out_byte, output kind, output offset,
        output field_last, output box_end, output status, input ready
    );
    modport sink (
        input valid, input out_byte, input kind, input offset,
        input field_last, input box_end, input status, output ready
    );

endinterface : kvbd_out_if

@@ design/key_value_box_deframer.sv @@
// ----------------------------------------------------------------------------
// key_value_box_deframer
// Deframes length-prefixed key/value boxes, one received byte per request.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake     Payload
//  i_in      in    valid/ready   command, data_byte
//  o_out     out   valid/ready   out_byte, kind, offset, field_last, box_end, status
//
//  One request per cycle sustained while o_out is ready; a taken request passes
//  the input register, then parser logic into the result register, to o_out.
//  The parser state updates as a request moves from the input register into
//  the result register, so back-to-back requests see each other's effect.
//  A stall on o_out holds the result register, then the input register.
//  i_rst_n is synchronous, active low, holds i_in.ready low while asserted
//  and leaves the parser at a box start.
// ----------------------------------------------------------------------------
module key_value_box_deframer
    import kvbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    kvbd_in_if.sink    i_in,
    kvbd_out_if.source o_out
);

    // Input register
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;

    // Parser state
    t_phase      r_phase,    n_phase;
    logic        r_second,   n_second;
    logic [7:0]  r_key_len,  n_key_len;
    logic [15:0] r_val_len,  n_val_len;
    logic [15:0] r_count,    n_count;
    logic        r_has_pair, n_has_pair;
    t_error      r_error,    n_error;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    t_kind       r_kind,     n_kind;
    logic [15:0] r_offset,   n_offset;
    logic        r_last,     n_last;
    logic        r_bend,     n_bend;
    t_status     r_status,   n_status;

    logic        w_advance;
    logic [15:0] w_count_inc;

    // Pipeline flow; no request is taken while in reset
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || w_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_cmd  <= i_in.command;
            r_in_byte <= i_in.data_byte;
        end
    end

    assign w_count_inc = r_count + 16'd1;

    // Parser: classify the registered byte and work out the next state
    always_comb begin
        n_phase    = r_phase;
        n_second   = r_second;
        n_key_len  = r_key_len;
        n_val_len  = r_val_len;
        n_count    = r_count;
        n_has_pair = r_has_pair;
        n_error    = r_error;

        n_out_byte = r_in_byte;
        n_kind     = KIND_NONE;
        n_offset   = 16'd0;
        n_last     = 1'b0;
        n_bend     = 1'b0;
        n_status   = ST_OK;

        if (r_in_cmd == CMD_RESET) begin
            n_phase    = PH_KEY_LEN;
            n_second   = 1'b0;
            n_key_len  = 8'd0;
            n_val_len  = 16'd0;
            n_count    = 16'd0;
            n_has_pair = 1'b0;
            n_error    = ERR_NONE;
            n_out_byte = 8'd0;
        end else if (r_error != ERR_NONE) begin
            n_status = ST_REFUSED;
        end else begin
            unique case (r_phase)
                PH_KEY_LEN: begin
                    if (!r_second) begin
                        n_kind = KIND_KLEN_HI;
                        if (r_in_byte != 8'd0) begin
                            n_error  = ERR_BAD_KEY_LEN;
                            n_status = ST_BAD_KEY_LEN;
                        end else begin
                            n_second = 1'b1;
                        end
                    end else begin
                        n_second  = 1'b0;
                        n_key_len = r_in_byte;
                        if (r_in_byte == 8'd0) begin
                            // zero key length closes the box
                            n_kind = KIND_BOX_END;
                            n_bend = 1'b1;
                            if (!r_has_pair) begin
                                n_error  = ERR_EMPTY_BOX;
                                n_status = ST_EMPTY_BOX;
                            end
                            n_has_pair = 1'b0;
                        end else begin
                            n_kind   = KIND_KLEN_LO;
                            n_offset = 16'd1;
                            n_count  = 16'd0;
                            n_phase  = PH_KEY_DATA;
                        end
                    end
                end
                PH_KEY_DATA: begin
                    n_kind   = KIND_KEY;
                    n_offset = r_count;
                    n_count  = w_count_inc;
                    if (w_count_inc >= {8'd0, r_key_len}) begin
                        n_last  = 1'b1;
                        n_count = 16'd0;
                        n_phase = PH_VAL_LEN;
                    end
                end
                PH_VAL_LEN: begin
                    if (!r_second) begin
                        n_kind    = KIND_VLEN_HI;
                        n_val_len = {r_in_byte, 8'd0};
                        n_second  = 1'b1;
                    end else begin
                        n_kind    = KIND_VLEN_LO;
                        n_offset  = 16'd1;
                        n_second  = 1'b0;
                        n_val_len = {r_val_len[15:8], r_val_len[7:0] | r_in_byte};
                        n_count   = 16'd0;
                        if ({r_val_len[15:8], r_val_len[7:0] | r_in_byte} == 16'd0) begin
                            // empty value completes the pair here
                            n_last     = 1'b1;
                            n_has_pair = 1'b1;
                            n_phase    = PH_KEY_LEN;
                        end else begin
                            n_phase = PH_VAL_DATA;
                        end
                    end
                end
                PH_VAL_DATA: begin
                    n_kind   = KIND_VALUE;
                    n_offset = r_count;
                    n_count  = w_count_inc;
                    if (w_count_inc >= r_val_len) begin
                        n_last     = 1'b1;
                        n_has_pair = 1'b1;
                        n_count    = 16'd0;
                        n_phase    = PH_KEY_LEN;
                    end
                end
                default: begin
                    n_phase = PH_KEY_LEN;
                end
            endcase
        end
    end

    // State update on each request that moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_KEY_LEN;
            r_second   <= 1'b0;
            r_key_len  <= 8'd0;
            r_val_len  <= 16'd0;
            r_count    <= 16'd0;
            r_has_pair <= 1'b0;
            r_error    <= ERR_NONE;
        end else if (w_advance) begin
            r_phase    <= n_phase;
            r_second   <= n_second;
            r_key_len  <= n_key_len;
            r_val_len  <= n_val_len;
            r_count    <= n_count;
            r_has_pair <= n_has_pair;
            r_error    <= n_error;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_byte <= n_out_byte;
            r_kind     <= n_kind;
            r_offset   <= n_offset;
            r_last     <= n_last;
            r_bend     <= n_bend;
            r_status   <= n_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.kind       = r_kind;
    assign o_out.offset     = r_offset;
    assign o_out.field_last = r_last;
    assign o_out.box_end    = r_bend;
    assign o_out.status     = r_status;

endmodule : key_value_box_deframer

@@ bench/key_value_box_deframer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_box_deframer_tb
// Drives received bytes and parser resets into the deframer. The run opens
// with a short table of directed requests and follows with random boxes,
// broken boxes and noise. A local parser model works out the classification
// of every accepted request, and each result is checked field by field in
// order. Both channels idle at random. Once, the result side holds off for a
// long stretch so that the block backs up and stalls its request channel.
// ----------------------------------------------------------------------------
module key_value_box_deframer_tb;
    import kvbd_pkg::*;

    localparam int          N_DIRECTED   = 28;
    localparam int          N_RANDOM     = 950;
    localparam int unsigned HOLD_AT      = 400;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // One classified byte
    typedef struct packed {
        logic [7:0]  octet;
        t_kind       kind;
        logic [15:0] offset;
        logic        last;
        logic        box_end;
        t_status     status;
    } t_result;

    // One request, with a typed-in expectation where the table gives one
    typedef struct packed {
        logic    cmd;
        logic [7:0] octet;
        logic    typed;
        t_result exp;
    } t_request;

    // Row of the directed table; typed rows all expect offset 0, last 0
    typedef struct packed {
        logic       cmd;
        logic [7:0] octet;
        logic       typed;
        logic [7:0] exp_octet;
        t_kind      exp_kind;
        logic       exp_end;
        t_status    exp_status;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kvbd_in_if  in_ch ();
    kvbd_out_if out_ch ();

    key_value_box_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    t_request    request_q [$];
    t_result     expected_q [$];
    int unsigned n_errors    = 0;
    int unsigned cycle_count = 0;
    bit          sink_held   = 1'b0;

    // Parser model state
    t_phase      pr_phase;
    logic        pr_second;
    logic [7:0]  pr_key_len;
    logic [15:0] pr_val_len;
    logic [15:0] pr_fetched;
    logic        pr_has_pair;
    t_error      pr_err;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic void clear_parser();
        pr_phase    = PH_KEY_LEN;
        pr_second   = 1'b0;
        pr_key_len  = 8'h00;
        pr_val_len  = 16'h0000;
        pr_fetched  = 16'h0000;
        pr_has_pair = 1'b0;
        pr_err      = ERR_NONE;
    endfunction

    // Classify one request and advance the parser model
    function automatic t_result classify_byte(input logic cmd, input logic [7:0] b);
        t_result     r;
        logic [15:0] next_count;
        r.octet   = b;
        r.kind    = KIND_NONE;
        r.offset  = 16'd0;
        r.last    = 1'b0;
        r.box_end = 1'b0;
        r.status  = ST_OK;
        next_count = pr_fetched + 16'd1;
        if (cmd == CMD_RESET) begin
            clear_parser();
            r.octet = 8'h00;
        end else if (pr_err != ERR_NONE) begin
            r.status = ST_REFUSED;
        end else begin
            case (pr_phase)
                PH_KEY_LEN: begin
                    if (!pr_second) begin
                        r.kind = KIND_KLEN_HI;
                        if (b != 8'h00) begin
                            pr_err   = ERR_BAD_KEY_LEN;
                            r.status = ST_BAD_KEY_LEN;
                        end else begin
                            pr_second = 1'b1;
                        end
                    end else begin
                        pr_second  = 1'b0;
                        pr_key_len = b;
                        if (b == 8'h00) begin
                            // box closes; empty box is an error
                            r.kind    = KIND_BOX_END;
                            r.box_end = 1'b1;
                            if (!pr_has_pair) begin
                                pr_err   = ERR_EMPTY_BOX;
                                r.status = ST_EMPTY_BOX;
                            end
                            pr_has_pair = 1'b0;
                        end else begin
                            r.kind     = KIND_KLEN_LO;
                            r.offset   = 16'd1;
                            pr_fetched = 16'd0;
                            pr_phase   = PH_KEY_DATA;
                        end
                    end
                end
                PH_KEY_DATA: begin
                    r.kind   = KIND_KEY;
                    r.offset = pr_fetched;
                    if (next_count >= {8'h00, pr_key_len}) begin
                        r.last     = 1'b1;
                        pr_fetched = 16'd0;
                        pr_phase   = PH_VAL_LEN;
                    end else begin
                        pr_fetched = next_count;
                    end
                end
                PH_VAL_LEN: begin
                    if (!pr_second) begin
                        r.kind     = KIND_VLEN_HI;
                        pr_val_len = {b, 8'h00};
                        pr_second  = 1'b1;
                    end else begin
                        r.kind     = KIND_VLEN_LO;
                        r.offset   = 16'd1;
                        pr_second  = 1'b0;
                        pr_val_len = pr_val_len | {8'h00, b};
                        pr_fetched = 16'd0;
                        // zero-length value completes the pair here
                        if (pr_val_len == 16'd0) begin
                            r.last      = 1'b1;
                            pr_has_pair = 1'b1;
                            pr_phase    = PH_KEY_LEN;
                        end else begin
                            pr_phase = PH_VAL_DATA;
                        end
                    end
                end
                default: begin
                    r.kind   = KIND_VALUE;
                    r.offset = pr_fetched;
                    if (next_count >= pr_val_len) begin
                        r.last      = 1'b1;
                        pr_has_pair = 1'b1;
                        pr_fetched  = 16'd0;
                        pr_phase    = PH_KEY_LEN;
                    end else begin
                        pr_fetched = next_count;
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic push_item(input logic cmd, input logic [7:0] octet);
        t_request req;
        req       = '0;
        req.cmd   = cmd;
        req.octet = octet;
        request_q.push_back(req);
    endtask

    // Directed table: errors, refusal, resets, zero-length and maximum
    // value lengths, good box end, then an empty box straight after it
    task automatic load_directed();
        t_directed_row rows [N_DIRECTED];
        t_request      req;
        rows = '{
            '{CMD_RESET, 8'hA5, 1'b1, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h80, 1'b1, 8'h80, KIND_KLEN_HI, 1'b0, ST_BAD_KEY_LEN},
            '{CMD_BYTE,  8'hFF, 1'b1, 8'hFF, KIND_NONE,    1'b0, ST_REFUSED},
            '{CMD_RESET, 8'hFF, 1'b1, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h01, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'hFF, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h02, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h7E, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h81, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'hFF, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'hFF, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_RESET, 8'h3C, 1'b1, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h01, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h33, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h02, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'hC3, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h3C, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b1, 8'h00, KIND_BOX_END, 1'b1, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b0, 8'h00, KIND_NONE,    1'b0, ST_OK},
            '{CMD_BYTE,  8'h00, 1'b1, 8'h00, KIND_BOX_END, 1'b1, ST_EMPTY_BOX},
            '{CMD_RESET, 8'h00, 1'b1, 8'h00, KIND_NONE,    1'b0, ST_OK}
        };
        foreach (rows[i]) begin
            req             = '0;
            req.cmd         = rows[i].cmd;
            req.octet       = rows[i].octet;
            req.typed       = rows[i].typed;
            req.exp.octet   = rows[i].exp_octet;
            req.exp.kind    = rows[i].exp_kind;
            req.exp.box_end = rows[i].exp_end;
            req.exp.status  = rows[i].exp_status;
            request_q.push_back(req);
        end
    endtask

    // Mostly well-formed boxes; the rest cut short, bad or empty boxes and
    // noise, each followed by a parser reset
    task automatic build_random();
        int unsigned sel, n_pairs, klen, vlen, n_junk;
        while (request_q.size() < N_DIRECTED + N_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                n_pairs = $urandom_range(1, 4);
                repeat (n_pairs) begin
                    klen = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(1, 8);
                    push_item(CMD_BYTE, 8'h00);
                    push_item(CMD_BYTE, klen[7:0]);
                    repeat (klen) push_item(CMD_BYTE, 8'($urandom));
                    sel = $urandom_range(0, 39);
                    if (sel == 0)
                        vlen = $urandom_range(256, 400);
                    else if (sel < 10)
                        vlen = 0;
                    else
                        vlen = $urandom_range(1, 12);
                    push_item(CMD_BYTE, vlen[15:8]);
                    push_item(CMD_BYTE, vlen[7:0]);
                    repeat (vlen) push_item(CMD_BYTE, 8'($urandom));
                end
                push_item(CMD_BYTE, 8'h00);
                push_item(CMD_BYTE, 8'h00);
            end else begin
                if (sel < 88) begin
                    // box cut short somewhere in its first pair
                    klen   = $urandom_range(1, 8);
                    n_junk = $urandom_range(0, klen + 3);
                    push_item(CMD_BYTE, 8'h00);
                    push_item(CMD_BYTE, klen[7:0]);
                    repeat (n_junk) push_item(CMD_BYTE, 8'($urandom));
                end else if (sel < 94) begin
                    // bad key length, then refused bytes
                    push_item(CMD_BYTE, 8'($urandom_range(1, 255)));
                    repeat ($urandom_range(0, 3)) push_item(CMD_BYTE, 8'($urandom));
                end else if (sel < 98) begin
                    // empty box, then a refused byte
                    push_item(CMD_BYTE, 8'h00);
                    push_item(CMD_BYTE, 8'h00);
                    push_item(CMD_BYTE, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 4))
                        push_item(1'($urandom_range(0, 1)), 8'($urandom));
                end
                push_item(CMD_RESET, 8'($urandom));
            end
        end
    endtask

    // Request side: random gaps, none while the result side is held off
    task automatic send_requests();
        t_request    req;
        t_result     predicted;
        int unsigned gap, n_sent;
        bit          calm;
        n_sent = 0;
        calm   = 1'b0;
        while (request_q.size() != 0) begin
            req = request_q.pop_front();
            if (n_sent % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = (calm || sink_held) ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.command   <= req.cmd;
            in_ch.data_byte <= req.octet;
            do @(posedge i_clk); while (!in_ch.ready);
            predicted = classify_byte(req.cmd, req.octet);
            expected_q.push_back(req.typed ? req.exp : predicted);
            n_sent++;
        end
        in_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off, in-order check
    task automatic take_results();
        t_result     got, want;
        int unsigned gap, n_taken;
        bit          calm;
        n_taken = 0;
        calm    = 1'b0;
        forever begin
            if (n_taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 18);
            if (n_taken == HOLD_AT) begin
                sink_held = 1'b1;
                gap       = HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            sink_held    = 1'b0;
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.octet   = out_ch.out_byte;
            got.kind    = t_kind'(out_ch.kind);
            got.offset  = out_ch.offset;
            got.last    = out_ch.field_last;
            got.box_end = out_ch.box_end;
            got.status  = t_status'(out_ch.status);
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", n_taken));
            end else begin
                want = expected_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "result %0d: got %02h/%0d/%0d/%b/%b/%0d, want %02h/%0d/%0d/%b/%b/%0d",
                        n_taken, got.octet, got.kind, got.offset, got.last, got.box_end,
                        got.status, want.octet, want.kind, want.offset, want.last,
                        want.box_end, want.status));
            end
            n_taken++;
        end
    endtask

    // Reset, stimulus, drain and verdict
    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_BYTE;
        in_ch.data_byte <= 8'h00;
        out_ch.ready    <= 1'b0;
        clear_parser();
        load_directed();
        build_random();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_results();
        join_none
        send_requests();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule : key_value_box_deframer_tb

@@ sim.f @@
design/kvbd_pkg.sv
design/kvbd_in_if.sv
design/kvbd_out_if.sv
design/key_value_box_deframer.sv
bench/key_value_box_deframer_tb.sv
